// File: rtl/set_assoc_cache_fifo_sim_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative cache model
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_FIFO_SIM_MACROS_SVH
`define SET_ASSOC_CACHE_FIFO_SIM_MACROS_SVH
`ifndef SYNTH
// check on every rising edge outside reset
`define SACF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check on every rising edge, reset included
`define SACF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SACF_ASSERT(lbl, clk, rstn, prop, msg)
`define SACF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/sacf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacf_pkg
// Shared constants, register indexes and types of the cache model.
// ----------------------------------------------------------------------------
package sacf_pkg;

  localparam int unsigned DEF_MAX_SET_BITS = 6;
  localparam int unsigned DEF_WAYS         = 8;
  localparam int unsigned DEF_ADDR_WIDTH   = 64;

  localparam int unsigned ADDR_FIELD_W = 64;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned HIT_W        = 2;
  localparam int unsigned SIB_W        = 3;
  localparam int unsigned BOB_W        = 6;
  localparam int unsigned WIU_W        = 4;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 6;
  localparam int unsigned SHAMT_W      = 7;

  localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd2;

  localparam logic [WIU_W-1:0] WAYS_RESET = 4'd8;

  typedef struct packed {
    logic hit;
    logic full;
  } sacf_look_t;

endpackage

// File: rtl/sacf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacf_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sacf_ram #(
  parameter int unsigned ADDR_W = 6,
  parameter int unsigned DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sacf_addr_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacf_addr_split
// Split a byte address into set index and tag from the configured field sizes.
// ----------------------------------------------------------------------------
module sacf_addr_split #(
  parameter  int unsigned MAX_SET_BITS = 6,
  parameter  int unsigned ADDR_WIDTH   = 64,
  localparam int unsigned SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  logic [sacf_pkg::ADDR_FIELD_W-1:0] address_i,
  input  logic [sacf_pkg::SIB_W-1:0]        set_bits_i,
  input  logic [sacf_pkg::BOB_W-1:0]        blk_bits_i,
  output logic [SET_W-1:0]                  set_o,
  output logic [ADDR_WIDTH-1:0]             tag_o
);
  import sacf_pkg::*;

  localparam int unsigned WIDE_W = (ADDR_WIDTH > SET_W) ? ADDR_WIDTH : SET_W;
  localparam logic [SIB_W-1:0] SET_CAP =
      (MAX_SET_BITS > 7) ? 3'd7 : SIB_W'(MAX_SET_BITS);

  logic [WIDE_W-1:0]  addr_w;
  logic [WIDE_W-1:0]  blk_shift;
  logic [SIB_W-1:0]   set_bits;
  logic [SET_W-1:0]   set_mask;
  logic [SHAMT_W-1:0] tag_shamt;

  always_comb begin
    // address bits at or above ADDR_WIDTH read as zero
    addr_w    = WIDE_W'(address_i[ADDR_WIDTH-1:0]);
    set_bits  = (set_bits_i > SET_CAP) ? SET_CAP : set_bits_i;
    blk_shift = addr_w >> blk_bits_i;
    set_mask  = ~({SET_W{1'b1}} << set_bits);
    set_o     = blk_shift[SET_W-1:0] & set_mask;
    tag_shamt = SHAMT_W'(blk_bits_i) + SHAMT_W'(set_bits);
    tag_o     = ADDR_WIDTH'(addr_w >> tag_shamt);
  end

endmodule

// File: rtl/sacf_way_sel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacf_way_sel
// Tag compare over one set row, first free way search and FIFO victim choice.
// ----------------------------------------------------------------------------
module sacf_way_sel #(
  parameter  int unsigned WAYS       = 8,
  parameter  int unsigned ADDR_WIDTH = 64,
  localparam int unsigned WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic [ADDR_WIDTH-1:0]            tag_i,
  input  logic [WAYS-1:0][ADDR_WIDTH-1:0]  tags_i,
  input  logic [WAYS-1:0]                  valid_i,
  input  logic [WAY_W-1:0]                 ptr_i,
  input  logic [sacf_pkg::WIU_W-1:0]       ways_cfg_i,
  output sacf_pkg::sacf_look_t             look_o,
  output logic [WAY_W-1:0]                 target_o,
  output logic [WAY_W-1:0]                 next_ptr_o
);
  import sacf_pkg::*;

  localparam int unsigned CNT_W = $clog2(WAYS + 1);

  logic [7:0]       cfg_ext;
  logic [CNT_W-1:0] ways_eff;
  logic [WAYS-1:0]  in_use;
  logic [WAYS-1:0]  match;
  logic [WAYS-1:0]  free;
  logic [WAY_W-1:0] free_way;
  logic             free_found;
  logic [CNT_W-1:0] vict_ext;
  logic [CNT_W-1:0] vict_inc;

  always_comb begin
    cfg_ext = 8'(ways_cfg_i);
    if (cfg_ext == 8'd0) begin
      ways_eff = CNT_W'(1);
    end else if (cfg_ext > 8'(WAYS)) begin
      ways_eff = CNT_W'(WAYS);
    end else begin
      ways_eff = CNT_W'(cfg_ext);
    end

    for (int w = 0; w < WAYS; w++) begin
      in_use[w] = CNT_W'(w) < ways_eff;
      match[w]  = in_use[w] & valid_i[w] & (tags_i[w] == tag_i);
      free[w]   = in_use[w] & ~valid_i[w];
    end

    // lowest free way wins
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (free[w]) begin
        free_way = WAY_W'(w);
      end
    end
    free_found = |free;

    // a stale pointer beyond the ways in use restarts at way 0
    vict_ext = CNT_W'(ptr_i);
    if (vict_ext >= ways_eff) begin
      vict_ext = '0;
    end
    vict_inc   = vict_ext + CNT_W'(1);
    next_ptr_o = (vict_inc == ways_eff) ? '0 : WAY_W'(vict_inc);

    look_o.hit  = |match;
    look_o.full = ~free_found;
    target_o    = free_found ? free_way : WAY_W'(vict_ext);
  end

endmodule

// File: rtl/set_assoc_cache_fifo_sim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_sim
// Set-associative cache hit/miss model with per-set FIFO replacement.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | handshake
//  ---------+------------------------------------------+---------------------
//  request  | op_i, address_i                          | start && !busy
//  result   | hit_count_o, missed_o, evicted_o         | result_valid_o strobe
//  config   | cfg_idx_i, cfg_wdata_i                   | cfg_we_i
//
//  A request reads the set row from the tag and meta RAMs at the accept
//  edge; the row is compared and written back on the next edge, where the
//  result is registered and shown for one cycle while busy drops.
//  After reset a clearing pass zeroes the meta RAM, one set per cycle,
//  through every set (64 by default); busy stays high meanwhile.
//  The receiver cannot stall; every request gives exactly one result.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_fifo_sim_macros.svh"

module set_assoc_cache_fifo_sim #(
  parameter int unsigned MAX_SET_BITS = sacf_pkg::DEF_MAX_SET_BITS,
  parameter int unsigned WAYS         = sacf_pkg::DEF_WAYS,
  parameter int unsigned ADDR_WIDTH   = sacf_pkg::DEF_ADDR_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [sacf_pkg::OP_W-1:0]         op_i,
  input  logic [sacf_pkg::ADDR_FIELD_W-1:0] address_i,
  output logic                              result_valid_o,
  output logic [sacf_pkg::HIT_W-1:0]        hit_count_o,
  output logic                              missed_o,
  output logic                              evicted_o,
  input  logic                              cfg_we_i,
  input  logic [sacf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sacf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import sacf_pkg::*;

  localparam int unsigned SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned TAG_ROW_W = WAYS * ADDR_WIDTH;
  localparam int unsigned META_W    = WAY_W + WAYS;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_e;

  typedef logic [WAYS-1:0][ADDR_WIDTH-1:0] tag_row_t;

  state_e              state_q;
  logic [SET_W-1:0]    clr_idx_q;
  logic [OP_W-1:0]     op_q;
  logic [SET_W-1:0]    set_q;
  logic [ADDR_WIDTH-1:0] tag_q;
  logic                result_valid_q;
  logic [HIT_W-1:0]    hit_count_q;
  logic                missed_q;
  logic                evicted_q;

  logic [SIB_W-1:0]    set_bits_q;
  logic [BOB_W-1:0]    blk_bits_q;
  logic [WIU_W-1:0]    ways_q;

  logic                accept;
  logic [SET_W-1:0]    split_set;
  logic [ADDR_WIDTH-1:0] split_tag;

  tag_row_t            tags_rd;
  tag_row_t            tags_wr;
  logic [TAG_ROW_W-1:0] tag_rdata;
  logic [META_W-1:0]   meta_rdata;
  logic [WAYS-1:0]     valid_rd;
  logic [WAYS-1:0]     valid_wr;
  logic [WAY_W-1:0]    ptr_rd;
  logic [WAY_W-1:0]    ptr_wr;

  sacf_look_t          look;
  logic [WAY_W-1:0]    target;
  logic [WAY_W-1:0]    next_ptr;

  logic                fill;
  logic                clearing;
  logic                tag_we;
  logic                meta_we;
  logic [SET_W-1:0]    meta_waddr;
  logic [META_W-1:0]   meta_wdata;
  logic [HIT_W-1:0]    hit_count_d;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign clearing = (state_q == S_CLEAR);

  sacf_addr_split #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_split (
    .address_i  (address_i),
    .set_bits_i (set_bits_q),
    .blk_bits_i (blk_bits_q),
    .set_o      (split_set),
    .tag_o      (split_tag)
  );

  sacf_ram #(
    .ADDR_W (SET_W),
    .DATA_W (TAG_ROW_W)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (set_q),
    .wdata_i (tags_wr),
    .re_i    (accept),
    .raddr_i (split_set),
    .rdata_o (tag_rdata)
  );

  sacf_ram #(
    .ADDR_W (SET_W),
    .DATA_W (META_W)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (accept),
    .raddr_i (split_set),
    .rdata_o (meta_rdata)
  );

  assign tags_rd            = tag_rdata;
  assign {ptr_rd, valid_rd} = meta_rdata;

  sacf_way_sel #(
    .WAYS       (WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_way_sel (
    .tag_i      (tag_q),
    .tags_i     (tags_rd),
    .valid_i    (valid_rd),
    .ptr_i      (ptr_rd),
    .ways_cfg_i (ways_q),
    .look_o     (look),
    .target_o   (target),
    .next_ptr_o (next_ptr)
  );

  always_comb begin
    fill             = (state_q == S_LOOK) && !look.hit;
    tags_wr          = tags_rd;
    tags_wr[target]  = tag_q;
    valid_wr         = valid_rd;
    valid_wr[target] = 1'b1;
    // advance the FIFO pointer only when a valid line is replaced
    ptr_wr           = look.full ? next_ptr : ptr_rd;
    tag_we           = fill;
    meta_we          = clearing || fill;
    meta_waddr       = clearing ? clr_idx_q : set_q;
    meta_wdata       = clearing ? '0 : {ptr_wr, valid_wr};
    hit_count_d      = HIT_W'(look.hit) + HIT_W'(op_q == OP_MODIFY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= '0;
      blk_bits_q <= '0;
      ways_q     <= WAYS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SET_BITS: set_bits_q <= cfg_wdata_i[SIB_W-1:0];
        CFG_BLK_BITS: blk_bits_q <= cfg_wdata_i[BOB_W-1:0];
        CFG_WAYS:     ways_q     <= cfg_wdata_i[WIU_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      clr_idx_q      <= '0;
      op_q           <= '0;
      set_q          <= '0;
      tag_q          <= '0;
      result_valid_q <= 1'b0;
      hit_count_q    <= '0;
      missed_q       <= 1'b0;
      evicted_q      <= 1'b0;
    end else begin
      result_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_idx_q <= clr_idx_q + SET_W'(1);
          if (clr_idx_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op_q    <= op_i;
            set_q   <= split_set;
            tag_q   <= split_tag;
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          result_valid_q <= 1'b1;
          hit_count_q    <= hit_count_d;
          missed_q       <= !look.hit;
          evicted_q      <= !look.hit && look.full;
          state_q        <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = result_valid_q;
  assign hit_count_o    = hit_count_q;
  assign missed_o       = missed_q;
  assign evicted_o      = evicted_q;

  `SACF_ASSERT(a_busy_after_accept, clk_i, rst_ni, accept |=> busy, "request accepted without busy")
  `SACF_ASSERT(a_result_after_look, clk_i, rst_ni, (state_q == S_LOOK) |=> result_valid_o, "lookup gave no result")
  `SACF_ASSERT(a_result_from_look, clk_i, rst_ni, result_valid_o |-> $past(state_q == S_LOOK), "result without lookup")
  `SACF_ASSERT_ALWAYS(a_evict_on_miss, clk_i, (result_valid_o && evicted_o) |-> missed_o, "eviction on a hit")
  `SACF_ASSERT(a_hit_counted, clk_i, rst_ni, (result_valid_o && !missed_o) |-> (hit_count_o != '0), "hit with zero count")

endmodule
